@@ design/ppcc_pkg.sv @@
// ----------------------------------------------------------------------------
// ppcc_pkg: shared types for the ping-pong capture controller
// Event and state codes, the controller state record and the step function
// of the capture sequencer.
// ----------------------------------------------------------------------------
package ppcc_pkg;

  // Largest frame length that is recorded; longer frames saturate to it
  localparam logic [15:0] MaxFrameBytes = 16'd32768;

  // Event codes on the command field; other codes act as a poll
  typedef enum logic [2:0] {
    CmdPicture  = 3'd0,
    CmdDmaDone  = 3'd1,
    CmdRelease1 = 3'd2,
    CmdRelease2 = 3'd3,
    CmdPoll     = 3'd4
  } cmd_e;

  // Sequencer modes
  typedef enum logic [2:0] {
    ModeWaitShutter = 3'd0,
    ModeWaitDma1    = 3'd1,
    ModeWaitDma2    = 3'd2,
    ModeIdle1       = 3'd3,
    ModeIdle2       = 3'd4
  } mode_e;

  // One event as held in the input register
  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] len;
  } item_t;

  // Controller state
  typedef struct packed {
    mode_e       mode;
    logic        target_is_two;
    logic        picture_pending;
    logic        dma_done;
    logic        buf_one_ready;
    logic        buf_two_ready;
    logic [15:0] pending_length;
    logic [15:0] stored_length_one;
    logic [15:0] stored_length_two;
  } ctl_state_t;

  // Pulses raised during one event
  typedef struct packed {
    logic start;
    logic buffer;
    logic shutter;
    logic overwrite;
  } pulse_t;

  typedef struct packed {
    ctl_state_t st;
    pulse_t     pl;
  } step_t;

  // One result item
  typedef struct packed {
    logic [2:0]  fsm_state;
    logic        next_target;
    logic        ready_one;
    logic        ready_two;
    logic        start_dma;
    logic        start_buffer;
    logic        shutter_press;
    logic        overwrite_warn;
    logic [15:0] length_one;
    logic [15:0] length_two;
  } outcome_t;

  // One step of the capture sequencer
  function automatic step_t fsm_step(ctl_state_t s);
    step_t r;
    r.st = s;
    r.pl = '0;
    case (s.mode)
      ModeWaitShutter: begin
        if (s.picture_pending) begin
          if (!s.target_is_two && s.buf_one_ready) begin
            r.st.mode = ModeIdle1;
          end else if (s.target_is_two && s.buf_two_ready) begin
            r.st.mode = ModeIdle2;
          end else begin
            r.st.picture_pending = 1'b0;
            r.pl.start           = 1'b1;
            r.pl.buffer          = s.target_is_two;
            if (!s.target_is_two) begin
              r.st.stored_length_one = s.pending_length;
              r.st.target_is_two     = 1'b1;
              r.st.mode              = ModeWaitDma1;
            end else begin
              r.st.stored_length_two = s.pending_length;
              r.st.target_is_two     = 1'b0;
              r.st.mode              = ModeWaitDma2;
            end
          end
        end
      end
      ModeWaitDma1: begin
        if (s.dma_done) begin
          r.st.dma_done      = 1'b0;
          r.pl.overwrite     = s.buf_one_ready;
          r.st.buf_one_ready = 1'b1;
          r.pl.shutter       = 1'b1;
          r.st.mode          = ModeWaitShutter;
        end
      end
      ModeWaitDma2: begin
        if (s.dma_done) begin
          r.st.dma_done      = 1'b0;
          r.pl.overwrite     = s.buf_two_ready;
          r.st.buf_two_ready = 1'b1;
          r.pl.shutter       = 1'b1;
          r.st.mode          = ModeWaitShutter;
        end
      end
      ModeIdle1: begin
        if (!s.buf_one_ready) begin
          r.st.mode = ModeWaitShutter;
        end
      end
      ModeIdle2: begin
        if (!s.buf_two_ready) begin
          r.st.mode = ModeWaitShutter;
        end
      end
      default: begin
        r.st.mode = ModeWaitShutter;
      end
    endcase
    return r;
  endfunction

endpackage

@@ design/ppcc_in_stage.sv @@
// ----------------------------------------------------------------------------
// ppcc_in_stage: input register
// Takes one event per cycle while not stalled, saturates the frame length
// and holds the item until the step logic consumes it.
// ----------------------------------------------------------------------------
module ppcc_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            command_i,
  input  logic [15:0]           frame_length_i,
  input  logic                  advance_i,
  output logic                  valid_o,
  output ppcc_pkg::item_t       item_o
);

  logic            valid_q, valid_d;
  ppcc_pkg::item_t item_q;
  logic            accept;
  logic [15:0]     len_sat;

  // Stall only while the held item cannot move on
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Clamp oversized frames
  assign len_sat = (frame_length_i > ppcc_pkg::MaxFrameBytes) ?
                   ppcc_pkg::MaxFrameBytes : frame_length_i;

  // Track occupancy
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.cmd <= command_i;
      item_q.len <= len_sat;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ design/ppcc_step.sv @@
// ----------------------------------------------------------------------------
// ppcc_step: event and sequencer step logic
// Applies one event to the controller state, runs one sequencer step, or two
// for a release, and forms the result item.
// ----------------------------------------------------------------------------
module ppcc_step (
  input  ppcc_pkg::item_t       item_i,
  input  ppcc_pkg::ctl_state_t  state_i,
  output ppcc_pkg::ctl_state_t  state_o,
  output ppcc_pkg::outcome_t    result_o
);

  ppcc_pkg::ctl_state_t ev;
  ppcc_pkg::step_t      first, second;
  logic                 two_steps;
  ppcc_pkg::pulse_t     pl;

  // Set the event flag or clear a ready flag
  always_comb begin
    ev        = state_i;
    two_steps = 1'b0;
    case (item_i.cmd)
      ppcc_pkg::CmdPicture: begin
        ev.pending_length  = item_i.len;
        ev.picture_pending = 1'b1;
      end
      ppcc_pkg::CmdDmaDone: begin
        ev.dma_done = 1'b1;
      end
      ppcc_pkg::CmdRelease1: begin
        ev.buf_one_ready = 1'b0;
        two_steps        = 1'b1;
      end
      ppcc_pkg::CmdRelease2: begin
        ev.buf_two_ready = 1'b0;
        two_steps        = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Next state: one or two sequencer steps
  always_comb begin
    first  = ppcc_pkg::fsm_step(ev);
    second = ppcc_pkg::fsm_step(first.st);
    if (two_steps) begin
      state_o = second.st;
      pl      = first.pl | second.pl;
    end else begin
      state_o = first.st;
      pl      = first.pl;
    end
  end

  // Result item
  always_comb begin
    result_o.fsm_state      = state_o.mode;
    result_o.next_target    = state_o.target_is_two;
    result_o.ready_one      = state_o.buf_one_ready;
    result_o.ready_two      = state_o.buf_two_ready;
    result_o.start_dma      = pl.start;
    result_o.start_buffer   = pl.start & pl.buffer;
    result_o.shutter_press  = pl.shutter;
    result_o.overwrite_warn = pl.overwrite;
    result_o.length_one     = state_o.stored_length_one;
    result_o.length_two     = state_o.stored_length_two;
  end

endmodule

@@ design/ppcc_out_stage.sv @@
// ----------------------------------------------------------------------------
// ppcc_out_stage: result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module ppcc_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  ppcc_pkg::outcome_t  result_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic                free_o,
  output ppcc_pkg::outcome_t  result_o
);

  logic               valid_q, valid_d;
  ppcc_pkg::outcome_t result_q;

  // Room for a new item when empty or draining this cycle
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture result
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

@@ design/ping_pong_capture_controller.sv @@
// ----------------------------------------------------------------------------
// ping_pong_capture_controller: double-buffered capture sequencer
// Alternates DMA between two frame buffers, never starting DMA into a
// buffer that still holds an unconsumed frame.
// ----------------------------------------------------------------------------
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+-----------------------------------
//   in      | in_valid_i  | in_stall_o  | command_i, frame_length_i
//   out     | out_valid_o | out_stall_i | fsm_state_o .. length_two_o
//
// One item per cycle while the output does not stall: an item is held in the
// input register; the step logic updates the controller state and fills the
// result register at the same edge, so the next item sees the updated state.
// An accepted item passes the input register, then the result register.
// Reset clears the controller state and both stage valid bits.
// A stall on the output holds the result register; the input register then
// fills and in_stall_o rises until the output drains.
module ping_pong_capture_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [15:0] frame_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  fsm_state_o,
  output logic        next_target_o,
  output logic        ready_one_o,
  output logic        ready_two_o,
  output logic        start_dma_o,
  output logic        start_buffer_o,
  output logic        shutter_press_o,
  output logic        overwrite_warn_o,
  output logic [15:0] length_one_o,
  output logic [15:0] length_two_o
);

  logic                 s1_valid;
  ppcc_pkg::item_t      s1_item;
  logic                 out_free;
  logic                 advance;
  ppcc_pkg::ctl_state_t state_q, state_d;
  ppcc_pkg::outcome_t   step_result;
  ppcc_pkg::outcome_t   out_result;

  // Move the held item on when the result register has room
  assign advance = s1_valid && out_free;

  ppcc_in_stage u_in_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .frame_length_i (frame_length_i),
    .advance_i      (advance),
    .valid_o        (s1_valid),
    .item_o         (s1_item)
  );

  ppcc_step u_step (
    .item_i   (s1_item),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (step_result)
  );

  // Commit controller state per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode              <= ppcc_pkg::ModeWaitShutter;
      state_q.target_is_two     <= 1'b0;
      state_q.picture_pending   <= 1'b0;
      state_q.dma_done          <= 1'b0;
      state_q.buf_one_ready     <= 1'b0;
      state_q.buf_two_ready     <= 1'b0;
      state_q.pending_length    <= '0;
      state_q.stored_length_one <= '0;
      state_q.stored_length_two <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  ppcc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (step_result),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .free_o      (out_free),
    .result_o    (out_result)
  );

  assign fsm_state_o      = out_result.fsm_state;
  assign next_target_o    = out_result.next_target;
  assign ready_one_o      = out_result.ready_one;
  assign ready_two_o      = out_result.ready_two;
  assign start_dma_o      = out_result.start_dma;
  assign start_buffer_o   = out_result.start_buffer;
  assign shutter_press_o  = out_result.shutter_press;
  assign overwrite_warn_o = out_result.overwrite_warn;
  assign length_one_o     = out_result.length_one;
  assign length_two_o     = out_result.length_two;

endmodule

@@ design/ppcc_checker.sv @@
// ----------------------------------------------------------------------------
// ppcc_checker: port-level checks for the capture controller
// Watches the result channel for handshake and sequencing consistency.
// ----------------------------------------------------------------------------
module ppcc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  fsm_state_o,
  input logic        ready_one_o,
  input logic        ready_two_o,
  input logic        start_dma_o,
  input logic        start_buffer_o,
  input logic        shutter_press_o,
  input logic        overwrite_warn_o,
  input logic [15:0] length_one_o,
  input logic [15:0] length_two_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(fsm_state_o) &&
      $stable(length_one_o) && $stable(length_two_o) && $stable(start_dma_o))
    else $error("stalled result changed");

  // A buffer is named only for a started transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_buffer_o |-> start_dma_o)
    else $error("start_buffer without start_dma");

  // Overwrite is only flagged on a DMA completion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overwrite_warn_o |-> shutter_press_o)
    else $error("overwrite without completion");

  // Idle one waits on a full buffer one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (fsm_state_o == ppcc_pkg::ModeIdle1) |-> ready_one_o)
    else $error("idle one with buffer one free");

  // Idle two waits on a full buffer two
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (fsm_state_o == ppcc_pkg::ModeIdle2) |-> ready_two_o)
    else $error("idle two with buffer two free");

endmodule

bind ping_pong_capture_controller ppcc_checker u_ppcc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .fsm_state_o      (fsm_state_o),
  .ready_one_o      (ready_one_o),
  .ready_two_o      (ready_two_o),
  .start_dma_o      (start_dma_o),
  .start_buffer_o   (start_buffer_o),
  .shutter_press_o  (shutter_press_o),
  .overwrite_warn_o (overwrite_warn_o),
  .length_one_o     (length_one_o),
  .length_two_o     (length_two_o)
);

@@ test/ping_pong_capture_controller_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ping_pong_capture_controller_tb: self-checking bench for the capture sequencer
// Sends capture events (picture, DMA done, releases, polls and unused codes)
// through the valid/stall input. A shadow of the sequencer predicts each
// result item, and every result that the block hands over is compared field
// by field. Both sides idle at random in the first two of three phases.
// ----------------------------------------------------------------------------
module ping_pong_capture_controller_tb;

  // Command codes with no event of their own; they act as a poll
  localparam logic [2:0] CmdUnused5 = 3'd5;
  localparam logic [2:0] CmdUnused6 = 3'd6;
  localparam logic [2:0] CmdUnused7 = 3'd7;

  localparam int RandomEvents = 780;
  localparam int DrainCycles  = 10;
  localparam int QuietLimit   = 2000;

  // Known results: state after reset, and the first saturated capture
  localparam ppcc_pkg::outcome_t ResetResult = '0;
  localparam ppcc_pkg::outcome_t FirstCaptureOne = {ppcc_pkg::ModeWaitDma1, 1'b1, 1'b0,
                                                    1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                                                    ppcc_pkg::MaxFrameBytes, 16'd0};

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  command_i;
  logic [15:0] frame_length_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  fsm_state_o;
  logic        next_target_o;
  logic        ready_one_o;
  logic        ready_two_o;
  logic        start_dma_o;
  logic        start_buffer_o;
  logic        shutter_press_o;
  logic        overwrite_warn_o;
  logic [15:0] length_one_o;
  logic [15:0] length_two_o;

  ping_pong_capture_controller u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .frame_length_i   (frame_length_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .fsm_state_o      (fsm_state_o),
    .next_target_o    (next_target_o),
    .ready_one_o      (ready_one_o),
    .ready_two_o      (ready_two_o),
    .start_dma_o      (start_dma_o),
    .start_buffer_o   (start_buffer_o),
    .shutter_press_o  (shutter_press_o),
    .overwrite_warn_o (overwrite_warn_o),
    .length_one_o     (length_one_o),
    .length_two_o     (length_two_o)
  );

  // Shadow copy of the sequencer
  typedef struct {
    ppcc_pkg::mode_e mode;
    bit              target_two;
    bit              picture_waiting;
    bit              dma_flag;
    bit              full_one;
    bit              full_two;
    logic [15:0]     waiting_length;
    logic [15:0]     length_one;
    logic [15:0]     length_two;
  } sequencer_t;

  // One line of the directed event list
  typedef struct {
    logic [2:0]         cmd;
    logic [15:0]        len;
    bit                 known;
    ppcc_pkg::outcome_t want;
  } event_row_t;

  sequencer_t seq;
  bit         saw_start;
  bit         saw_buffer;
  bit         saw_shutter;
  bit         saw_overwrite;

  ppcc_pkg::outcome_t pending_results[$];
  event_row_t         directed_events[$];
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 error_count;
  int                 events_sent;
  int                 results_seen;
  int                 dma_starts;
  int                 idle_entries;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Advance the shadow sequencer by one step
  function automatic void step_sequencer();
    case (seq.mode)
      ppcc_pkg::ModeWaitShutter: begin
        if (seq.picture_waiting) begin
          if (!seq.target_two && seq.full_one) begin
            seq.mode = ppcc_pkg::ModeIdle1;
          end else if (seq.target_two && seq.full_two) begin
            seq.mode = ppcc_pkg::ModeIdle2;
          end else begin
            seq.picture_waiting = 1'b0;
            saw_start           = 1'b1;
            saw_buffer          = seq.target_two;
            if (seq.target_two) begin
              seq.length_two = seq.waiting_length;
              seq.mode       = ppcc_pkg::ModeWaitDma2;
            end else begin
              seq.length_one = seq.waiting_length;
              seq.mode       = ppcc_pkg::ModeWaitDma1;
            end
            seq.target_two = !seq.target_two;
          end
        end
      end
      ppcc_pkg::ModeWaitDma1, ppcc_pkg::ModeWaitDma2: begin
        if (seq.dma_flag) begin
          seq.dma_flag = 1'b0;
          saw_shutter  = 1'b1;
          if (seq.mode == ppcc_pkg::ModeWaitDma1) begin
            saw_overwrite = saw_overwrite | seq.full_one;
            seq.full_one  = 1'b1;
          end else begin
            saw_overwrite = saw_overwrite | seq.full_two;
            seq.full_two  = 1'b1;
          end
          seq.mode = ppcc_pkg::ModeWaitShutter;
        end
      end
      ppcc_pkg::ModeIdle1: begin
        if (!seq.full_one) seq.mode = ppcc_pkg::ModeWaitShutter;
      end
      ppcc_pkg::ModeIdle2: begin
        if (!seq.full_two) seq.mode = ppcc_pkg::ModeWaitShutter;
      end
      default: begin
        seq.mode = ppcc_pkg::ModeWaitShutter;
      end
    endcase
  endfunction

  // Apply one event to the shadow and return the result item it causes
  function automatic ppcc_pkg::outcome_t predict_event(logic [2:0] cmd, logic [15:0] len);
    ppcc_pkg::outcome_t r;
    bit                 twice;
    twice         = 1'b0;
    saw_start     = 1'b0;
    saw_buffer    = 1'b0;
    saw_shutter   = 1'b0;
    saw_overwrite = 1'b0;
    case (cmd)
      ppcc_pkg::CmdPicture: begin
        seq.waiting_length  = (len > ppcc_pkg::MaxFrameBytes) ? ppcc_pkg::MaxFrameBytes : len;
        seq.picture_waiting = 1'b1;
      end
      ppcc_pkg::CmdDmaDone: seq.dma_flag = 1'b1;
      ppcc_pkg::CmdRelease1: begin
        seq.full_one = 1'b0;
        twice        = 1'b1;
      end
      ppcc_pkg::CmdRelease2: begin
        seq.full_two = 1'b0;
        twice        = 1'b1;
      end
      default: ;
    endcase
    step_sequencer();
    if (twice) step_sequencer();
    r.fsm_state      = seq.mode;
    r.next_target    = seq.target_two;
    r.ready_one      = seq.full_one;
    r.ready_two      = seq.full_two;
    r.start_dma      = saw_start;
    r.start_buffer   = saw_start & saw_buffer;
    r.shutter_press  = saw_shutter;
    r.overwrite_warn = saw_overwrite;
    r.length_one     = seq.length_one;
    r.length_two     = seq.length_two;
    return r;
  endfunction

  // Report one differing field
  task automatic field_mismatch(string name, int want, int got);
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    error_count++;
  endtask

  // Compare a result item with the oldest expectation
  task automatic check_result();
    ppcc_pkg::outcome_t want;
    if (pending_results.size() == 0) begin
      $display("%0t ns: result with none expected, actual state %0d", $time, fsm_state_o);
      error_count++;
    end else begin
      want = pending_results.pop_front();
      if (fsm_state_o != want.fsm_state)
        field_mismatch("fsm_state", want.fsm_state, fsm_state_o);
      if (next_target_o != want.next_target)
        field_mismatch("next_target", want.next_target, next_target_o);
      if (ready_one_o != want.ready_one)
        field_mismatch("ready_one", want.ready_one, ready_one_o);
      if (ready_two_o != want.ready_two)
        field_mismatch("ready_two", want.ready_two, ready_two_o);
      if (start_dma_o != want.start_dma)
        field_mismatch("start_dma", want.start_dma, start_dma_o);
      if (start_buffer_o != want.start_buffer)
        field_mismatch("start_buffer", want.start_buffer, start_buffer_o);
      if (shutter_press_o != want.shutter_press)
        field_mismatch("shutter_press", want.shutter_press, shutter_press_o);
      if (overwrite_warn_o != want.overwrite_warn)
        field_mismatch("overwrite_warn", want.overwrite_warn, overwrite_warn_o);
      if (length_one_o != want.length_one)
        field_mismatch("length_one", want.length_one, length_one_o);
      if (length_two_o != want.length_two)
        field_mismatch("length_two", want.length_two, length_two_o);
    end
    results_seen++;
  endtask

  // Offer one event, hold it until accepted, then record what it should cause
  task automatic send_event(logic [2:0] cmd, logic [15:0] len, bit known,
                            ppcc_pkg::outcome_t want);
    ppcc_pkg::outcome_t predicted;
    bit                 stalled;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    frame_length_i <= len;
    // Sample stall mid-cycle, where it holds its value for the coming edge
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    predicted = predict_event(cmd, len);
    pending_results.push_back(known ? want : predicted);
    events_sent++;
    if (predicted.start_dma) dma_starts++;
    if (predicted.fsm_state == ppcc_pkg::ModeIdle1 ||
        predicted.fsm_state == ppcc_pkg::ModeIdle2) idle_entries++;
  endtask

  // Stop offering and hold off until every expected result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic void add_event(logic [2:0] cmd, logic [15:0] len, bit known,
                                    ppcc_pkg::outcome_t want);
    event_row_t row;
    row.cmd   = cmd;
    row.len   = len;
    row.known = known;
    row.want  = want;
    directed_events.push_back(row);
  endfunction

  // Draw a frame length: mostly legal, some at and past the limit
  function automatic logic [15:0] pick_length();
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) return 16'($urandom_range(65535));
    if (sel < 60) return 16'($urandom_range(1023));
    if (sel < 80) return 16'($urandom_range(32760, 32776));
    return 16'($urandom_range(512, 32768));
  endfunction

  // Draw a command: mostly capture traffic, some polls and unused codes
  function automatic logic [2:0] pick_command();
    int sel;
    sel = $urandom_range(99);
    if (sel < 32) return ppcc_pkg::CmdPicture;
    if (sel < 60) return ppcc_pkg::CmdDmaDone;
    if (sel < 73) return ppcc_pkg::CmdRelease1;
    if (sel < 86) return ppcc_pkg::CmdRelease2;
    if (sel < 94) return ppcc_pkg::CmdPoll;
    if (sel < 96) return CmdUnused5;
    if (sel < 98) return CmdUnused6;
    return CmdUnused7;
  endfunction

  // Result side: check mid-cycle what the coming edge takes, stall at random
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) check_result();
      @(posedge clk_i);
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: end the run if nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(negedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
      if (quiet >= QuietLimit) begin
        $display("%0t ns: no progress for %0d cycles", $time, QuietLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    seq            = '{default: '0, mode: ppcc_pkg::ModeWaitShutter};
    error_count    = 0;
    events_sent    = 0;
    results_seen   = 0;
    dma_starts     = 0;
    idle_entries   = 0;
    send_idle_pct  = 9;
    recv_idle_pct  = 79;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    command_i      = ppcc_pkg::CmdPoll;
    frame_length_i = 16'd0;

    // Polls and unused codes straight after reset, early DMA done, then captures
    add_event(ppcc_pkg::CmdPoll,     16'h0000, 1'b1, ResetResult);
    add_event(CmdUnused5,            16'hFFFF, 1'b1, ResetResult);
    add_event(CmdUnused6,            16'hAAAA, 1'b1, ResetResult);
    add_event(CmdUnused7,            16'h5555, 1'b1, ResetResult);
    add_event(ppcc_pkg::CmdDmaDone,  16'h0000, 1'b0, ResetResult);
    add_event(ppcc_pkg::CmdPicture,  16'hFFFF, 1'b1, FirstCaptureOne);
    add_event(ppcc_pkg::CmdPoll,     16'h1234, 1'b0, ResetResult);
    add_event(ppcc_pkg::CmdPicture,  16'h0000, 1'b0, ResetResult);
    add_event(ppcc_pkg::CmdPicture,  16'h8001, 1'b0, ResetResult);
    add_event(ppcc_pkg::CmdPicture,  16'h7FFF, 1'b0, ResetResult);
    add_event(ppcc_pkg::CmdDmaDone,  16'hFFFF, 1'b0, ResetResult);
    add_event(ppcc_pkg::CmdPoll,     16'h0000, 1'b0, ResetResult);
    add_event(ppcc_pkg::CmdRelease2, 16'h0000, 1'b0, ResetResult);
    add_event(ppcc_pkg::CmdDmaDone,  16'h0000, 1'b0, ResetResult);
    add_event(ppcc_pkg::CmdRelease1, 16'hFFFF, 1'b0, ResetResult);
    add_event(ppcc_pkg::CmdPoll,     16'h0000, 1'b0, ResetResult);
    add_event(ppcc_pkg::CmdPicture,  16'h8000, 1'b0, ResetResult);
    add_event(ppcc_pkg::CmdDmaDone,  16'h0000, 1'b0, ResetResult);
    add_event(ppcc_pkg::CmdPicture,  16'h0001, 1'b0, ResetResult);
    add_event(ppcc_pkg::CmdPicture,  16'h0002, 1'b0, ResetResult);
    add_event(ppcc_pkg::CmdRelease1, 16'h0000, 1'b0, ResetResult);
    add_event(ppcc_pkg::CmdDmaDone,  16'h0000, 1'b0, ResetResult);
    add_event(ppcc_pkg::CmdPicture,  16'hFFFE, 1'b0, ResetResult);
    add_event(ppcc_pkg::CmdRelease2, 16'h0000, 1'b0, ResetResult);
    add_event(ppcc_pkg::CmdDmaDone,  16'h0000, 1'b0, ResetResult);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed events
    foreach (directed_events[i]) begin
      send_event(directed_events[i].cmd, directed_events[i].len,
                 directed_events[i].known, directed_events[i].want);
    end

    // Random events in three phases with their own idle rates, each starting from an empty pipe
    for (int phase = 0; phase < 3; phase++) begin
      drain_results();
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 79 : 0;
      recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 9 : 0;
      for (int n = 0; n < RandomEvents / 3; n++) begin
        send_event(pick_command(), pick_length(), 1'b0, ResetResult);
      end
    end

    // Wait for the last results, then let the pipe settle
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d capture events and checked %0d results.", events_sent, results_seen);
    $display("Predicted %0d DMA starts and %0d events ending in a full-buffer wait.",
             dma_starts, idle_entries);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", error_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
